### rtl/qn_pkg.sv
// ----------------------------------------------------------------------------
// qn_pkg: shared constants for the quaternion normalizer
// Fixed output formats and lane count used by the sum-of-squares stage, lanes, root unit and top.
// ----------------------------------------------------------------------------
package qn_pkg;

  localparam int LANES     = 4;    // x, y, z, w
  localparam int UNIT_W    = 16;   // Q1.14 unit component width
  localparam int UNIT_FRAC = 14;
  localparam int KW        = 16;   // width of 2x unit quotient, max 2^15
  localparam int MAG_W     = 17;   // magnitude field width
  localparam logic [MAG_W-1:0] MAG_MAX = 17'd131071;

endpackage

### rtl/qn_sumsq.sv
// ----------------------------------------------------------------------------
// qn_sumsq: component magnitudes, squares and sum of squares
// Stage 0 takes |c| and c^2 per lane; stage 1 adds the four squares.
// ----------------------------------------------------------------------------
module qn_sumsq #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  logic [W-1:0]           comp   [4],
  output logic [2*W-1:0]         sq_out [4],
  output logic                   neg_out[4],
  output logic [2*W:0]           s_out,
  output logic                   zero_out
);
  import qn_pkg::*;

  logic [2*W-1:0] sq0  [LANES];
  logic           neg0 [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic         n;
    logic [W-1:0] m;
    assign n = comp[i][W-1];
    assign m = n ? (~comp[i] + W'(1)) : comp[i];
    always_ff @(posedge clk) begin
      if (en[0]) begin
        sq0[i]  <= (2*W)'(m) * (2*W)'(m);
        neg0[i] <= n;
      end
      if (en[1]) begin
        sq_out[i]  <= sq0[i];
        neg_out[i] <= neg0[i];
      end
    end
  end

  logic [2*W:0] sum;
  assign sum = (2*W+1)'(sq0[0]) + (2*W+1)'(sq0[1]) + (2*W+1)'(sq0[2])
             + (2*W+1)'(sq0[3]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s_out    <= sum;
      zero_out <= (sum == '0);
    end
  end

endmodule

### rtl/qn_unit_lane.sv
// ----------------------------------------------------------------------------
// qn_unit_lane: one lane of the unit-component divider
// Finds k = floor(sqrt(c^2 * 2^30 / S)) one bit per stage, using shifts and
// subtracts and adds only (running k*S); extra stages just carry the result.
// ----------------------------------------------------------------------------
module qn_unit_lane #(
  parameter int W     = 16,
  parameter int NSTEP = 17
) (
  input  logic                        clk,
  input  logic [NSTEP-1:0]            en,
  input  logic [2*W-1:0]              sq_in,
  input  logic [2*W:0]                s_in,
  input  logic                        neg_in,
  output logic [qn_pkg::KW-1:0]       k_out,
  output logic                        neg_out
);
  import qn_pkg::*;

  localparam int SW = 2*W + 1;
  localparam int TW = 2*W + 29;
  localparam int PW = 2*W + 17;
  localparam int DW = 2*W + 34;

  logic [TW-1:0] rem  [NSTEP];
  logic [PW-1:0] prod [NSTEP];
  logic [KW-1:0] kq   [NSTEP];
  logic [SW-1:0] sq   [NSTEP];
  logic          ng   [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_stage
    logic [TW-1:0] r_i, r_n;
    logic [PW-1:0] p_i, p_n;
    logic [KW-1:0] k_i, k_n;
    logic [SW-1:0] s_i;
    logic          n_i;

    if (j == 0) begin : g_first
      assign r_i = TW'(sq_in) << (2*UNIT_FRAC + 2);
      assign p_i = '0;
      assign k_i = '0;
      assign s_i = s_in;
      assign n_i = neg_in;
    end else begin : g_next
      assign r_i = rem[j-1];
      assign p_i = prod[j-1];
      assign k_i = kq[j-1];
      assign s_i = sq[j-1];
      assign n_i = ng[j-1];
    end

    if (j < KW) begin : g_rec
      localparam int B = KW - 1 - j;
      logic [DW-1:0] dif;
      always_comb begin
        dif = (DW'(p_i) << (B + 1)) + (DW'(s_i) << (2*B));
        if (DW'(r_i) >= dif) begin
          r_n = r_i - TW'(dif);
          p_n = p_i + (PW'(s_i) << B);
          k_n = k_i | (KW'(1) << B);
        end else begin
          r_n = r_i;
          p_n = p_i;
          k_n = k_i;
        end
      end
    end else begin : g_pass
      assign r_n = r_i;
      assign p_n = p_i;
      assign k_n = k_i;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]  <= r_n;
        prod[j] <= p_n;
        kq[j]   <= k_n;
        sq[j]   <= s_i;
        ng[j]   <= n_i;
      end
    end
  end

  assign k_out   = kq[NSTEP-1];
  assign neg_out = ng[NSTEP-1];

endmodule

### rtl/qn_isqrt.sv
// ----------------------------------------------------------------------------
// qn_isqrt: pipelined integer square root of the sum of squares
// One result bit per stage, then saturation to the 17-bit magnitude field.
// ----------------------------------------------------------------------------
module qn_isqrt #(
  parameter int W     = 16,
  parameter int NSTEP = 17
) (
  input  logic                      clk,
  input  logic [NSTEP-1:0]          en,
  input  logic [2*W:0]              s_in,
  output logic [qn_pkg::MAG_W-1:0]  mag_out
);
  import qn_pkg::*;

  localparam int SW = 2*W + 1;
  localparam int NB = W + 1;
  localparam int DW = 2*W + 3;
  localparam int CW = (NB > MAG_W) ? NB : MAG_W;

  logic [SW-1:0] rem  [NSTEP];
  logic [NB-1:0] root [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_stage
    logic [SW-1:0] r_i, r_n;
    logic [NB-1:0] q_i, q_n;

    if (j == 0) begin : g_first
      assign r_i = s_in;
      assign q_i = '0;
    end else begin : g_next
      assign r_i = rem[j-1];
      assign q_i = root[j-1];
    end

    if (j < NB) begin : g_rec
      localparam int B = NB - 1 - j;
      logic [DW-1:0] dif;
      always_comb begin
        dif = (DW'(q_i) << (B + 1)) + (DW'(1) << (2*B));
        if (DW'(r_i) >= dif) begin
          r_n = r_i - SW'(dif);
          q_n = q_i | (NB'(1) << B);
        end else begin
          r_n = r_i;
          q_n = q_i;
        end
      end
    end else begin : g_pass
      assign r_n = r_i;
      assign q_n = q_i;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]  <= r_n;
        root[j] <= q_n;
      end
    end
  end

  logic [CW-1:0] root_ext;
  assign root_ext = CW'(root[NSTEP-1]);
  assign mag_out  = (root_ext > CW'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

endmodule

### rtl/quaternion_normalizer.sv
// ----------------------------------------------------------------------------
// quaternion_normalizer: unit quaternion and Euclidean length
// Pipelined normalizer, four divider lanes plus a square-root unit.
// ----------------------------------------------------------------------------
// Takes one quaternion per cycle while in_stall is low and returns one result
// per transfer, in order. The pipeline has a stage for |c| and c^2, one for
// the sum of squares S, then a bit-per-stage recurrence (16 stages in each
// unit lane, COMPONENT_WIDTH+1 in the root unit, the shorter one padded), and
// an output register where the lanes merge. Throughput is one transfer per
// cycle while out_stall is low. Every stage holds its own valid bit and only
// stalls when it is full and the stage after it cannot advance, so bubbles
// are squeezed out and input keeps flowing while a result waits. Unit
// components are round(|c|*2^14/sqrt(S)) with ties away from zero; magnitude
// is floor(sqrt(S)), saturated at 131071. An all-zero input sets zero_length
// and returns all-zero fields.
module quaternion_normalizer #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_x,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_y,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_z,
  input  logic signed [COMPONENT_WIDTH-1:0]  in_w,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [qn_pkg::UNIT_W-1:0]   unit_x,
  output logic signed [qn_pkg::UNIT_W-1:0]   unit_y,
  output logic signed [qn_pkg::UNIT_W-1:0]   unit_z,
  output logic signed [qn_pkg::UNIT_W-1:0]   unit_w,
  output logic [qn_pkg::MAG_W-1:0]           magnitude,
  output logic                               zero_length
);
  import qn_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int NSTEP = (W + 1 > KW) ? (W + 1) : KW;
  localparam int DEPTH = NSTEP + 3;   // square, sum, recurrence, merge

  // Per-stage occupancy and advance chain
  logic [DEPTH-1:0] vld;
  logic [DEPTH:0]   adv;

  assign adv[DEPTH] = ~out_stall;
  for (genvar i = 0; i < DEPTH; i++) begin : g_adv
    assign adv[i] = ~vld[i] | adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = ~adv[0];
  assign out_valid = vld[DEPTH-1];

  // Front end: magnitudes, squares, sum of squares
  logic [W-1:0]   comp   [LANES];
  logic [2*W-1:0] sq     [LANES];
  logic           neg    [LANES];
  logic [2*W:0]   ssum;
  logic           zero_s;

  assign comp[0] = in_x;
  assign comp[1] = in_y;
  assign comp[2] = in_z;
  assign comp[3] = in_w;

  qn_sumsq #(.W(W)) u_sumsq (
    .clk      (clk),
    .en       (adv[1:0]),
    .comp     (comp),
    .sq_out   (sq),
    .neg_out  (neg),
    .s_out    (ssum),
    .zero_out (zero_s)
  );

  // Divider lanes, one per component
  logic [KW-1:0] k_lane   [LANES];
  logic          neg_lane [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    qn_unit_lane #(.W(W), .NSTEP(NSTEP)) u_lane (
      .clk     (clk),
      .en      (adv[NSTEP+1:2]),
      .sq_in   (sq[i]),
      .s_in    (ssum),
      .neg_in  (neg[i]),
      .k_out   (k_lane[i]),
      .neg_out (neg_lane[i])
    );
  end

  // Length
  logic [MAG_W-1:0] mag_root;

  qn_isqrt #(.W(W), .NSTEP(NSTEP)) u_isqrt (
    .clk     (clk),
    .en      (adv[NSTEP+1:2]),
    .s_in    (ssum),
    .mag_out (mag_root)
  );

  // Zero flag rides alongside the recurrence
  logic zero_dly [NSTEP];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      zero_dly[0] <= zero_s;
    end
    for (int j = 1; j < NSTEP; j++) begin
      if (adv[j+2]) begin
        zero_dly[j] <= zero_dly[j-1];
      end
    end
  end

  // Merge: round k to the Q1.14 quotient, apply sign, gate on zero length
  logic [UNIT_W-1:0] unit_n [LANES];
  logic [UNIT_W-1:0] unit_q [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_merge
    logic [KW:0]       k_inc;
    logic [UNIT_W-1:0] q;
    assign k_inc = (KW+1)'(k_lane[i]) + (KW+1)'(1);
    assign q     = k_inc[UNIT_W:1];   // (k+1)/2, ties away from zero
    assign unit_n[i] = zero_dly[NSTEP-1] ? '0 :
                       (neg_lane[i] ? (~q + UNIT_W'(1)) : q);
  end

  always_ff @(posedge clk) begin
    if (adv[DEPTH-1]) begin
      for (int i = 0; i < LANES; i++) begin
        unit_q[i] <= unit_n[i];
      end
      magnitude   <= zero_dly[NSTEP-1] ? '0 : mag_root;
      zero_length <= zero_dly[NSTEP-1];
    end
  end

  assign unit_x = unit_q[0];
  assign unit_y = unit_q[1];
  assign unit_z = unit_q[2];
  assign unit_w = unit_q[3];

endmodule

### sim/tb_quaternion_normalizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_normalizer: self-checking bench for the quaternion normalizer
// Drives directed and random quaternions through a queue-fed driver, predicts
// unit components and length exactly, and checks every output transfer in
// order under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_quaternion_normalizer;
  import qn_pkg::*;

  localparam int CW = 16;

  typedef struct {
    logic signed [CW-1:0] x, y, z, w;
  } quat_t;

  typedef struct {
    logic signed [UNIT_W-1:0] ux, uy, uz, uw;
    logic [MAG_W-1:0]         mag;
    logic                     zero;
  } norm_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z, unit_w;
  logic [MAG_W-1:0] magnitude;
  logic zero_length;

  quat_t pending_quats[$];
  norm_t expected_norms[$];
  int    errors = 0;
  int    cycle = 0;
  bit    drain_pause = 0;    // sender waits for the pipe to empty
  bit    drain_done = 0;

  quaternion_normalizer #(.COMPONENT_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .unit_w(unit_w),
    .magnitude(magnitude), .zero_length(zero_length)
  );

  always #10 clk = ~clk;

  // |c| of a two's complement component, full magnitude for the most negative
  function automatic longint unsigned abs_comp(logic signed [CW-1:0] c);
    logic [CW-1:0] u;
    u = c[CW-1] ? (~c + 1'b1) : c;
    return longint'(u);
  endfunction

  // round(|c| * 2^14 / sqrt(s)), ties away from zero, by bitwise search:
  // keep q while (2q-1)^2 * s <= c^2 * 2^30
  function automatic logic [UNIT_W-1:0] unit_quot(longint unsigned c,
                                                  logic [127:0] s);
    logic [127:0] rhs, m, lhs;
    logic [UNIT_W-1:0] q;
    logic [UNIT_W-1:0] cand;
    rhs = (128'(c) * 128'(c)) << (2 * UNIT_FRAC + 2);
    q = '0;
    for (int b = UNIT_FRAC; b >= 0; b--) begin
      cand = q | (16'd1 << b);
      m = 2 * 128'(cand) - 1;
      lhs = m * m * s;
      if (lhs <= rhs) q = cand;
    end
    return q;
  endfunction

  function automatic norm_t normalize(quat_t q);
    norm_t r;
    longint unsigned a[4];
    logic [UNIT_W-1:0] u[4];
    logic [127:0] s;
    logic [127:0] root, cand;
    logic neg[4];
    neg[0] = q.x[CW-1]; neg[1] = q.y[CW-1]; neg[2] = q.z[CW-1]; neg[3] = q.w[CW-1];
    a[0] = abs_comp(q.x); a[1] = abs_comp(q.y);
    a[2] = abs_comp(q.z); a[3] = abs_comp(q.w);
    s = '0;
    for (int i = 0; i < 4; i++) s += 128'(a[i]) * 128'(a[i]);
    if (s == 0) begin
      r.ux = '0; r.uy = '0; r.uz = '0; r.uw = '0;
      r.mag = '0; r.zero = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      u[i] = unit_quot(a[i], s);
      if (neg[i]) u[i] = ~u[i] + 1'b1;
    end
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= s) root = cand;
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2]; r.uw = u[3];
    r.mag = (root > 128'(MAG_MAX)) ? MAG_MAX : root[MAG_W-1:0];
    r.zero = 1'b0;
    return r;
  endfunction

  function automatic quat_t mk(int x, int y, int z, int w);
    quat_t q;
    q.x = x[CW-1:0]; q.y = y[CW-1:0]; q.z = z[CW-1:0]; q.w = w[CW-1:0];
    return q;
  endfunction

  function automatic logic [CW-1:0] rand_comp(int kind);
    case (kind)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 64)) - 32);   // tiny values
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF; // extremes
      default: return CW'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // no idling at all during this stretch of cycles
  function automatic bit quiet();
    return cycle >= 200 && cycle < 700;
  endfunction

  always @(posedge clk) cycle <= cycle + 1;

  // Driver: records each transfer's prediction, then offers the next item
  always @(posedge clk) begin
    quat_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_norms.push_back(normalize(mk(in_x, in_y, in_z, in_w)));
      if (!drain_done && pending_quats.size() == 300) drain_pause = 1;
      if (drain_pause && expected_norms.size() == 0 && !in_valid) begin
        drain_pause = 0;
        drain_done = 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_quats.size() > 0 && !drain_pause &&
            (quiet() || $urandom_range(0, 99) >= 16)) begin
          q = pending_quats.pop_front();
          in_x <= q.x; in_y <= q.y; in_z <= q.z; in_w <= q.w;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, plus one long hold-off to back the pipe up
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (cycle >= 1000 && hold_cnt < 300) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet() && ($urandom_range(0, 99) < 16);
    end
  end

  // Monitor: compare every output transfer with the oldest prediction
  always @(posedge clk) begin
    norm_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_norms.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
      end else begin
        e = expected_norms.pop_front();
        if (unit_x !== e.ux) begin
          $display("%0t: unit_x exp %0d got %0d", $time, e.ux, unit_x); errors++;
        end
        if (unit_y !== e.uy) begin
          $display("%0t: unit_y exp %0d got %0d", $time, e.uy, unit_y); errors++;
        end
        if (unit_z !== e.uz) begin
          $display("%0t: unit_z exp %0d got %0d", $time, e.uz, unit_z); errors++;
        end
        if (unit_w !== e.uw) begin
          $display("%0t: unit_w exp %0d got %0d", $time, e.uw, unit_w); errors++;
        end
        if (magnitude !== e.mag) begin
          $display("%0t: magnitude exp %0d got %0d", $time, e.mag, magnitude); errors++;
        end
        if (zero_length !== e.zero) begin
          $display("%0t: zero_length exp %0b got %0b", $time, e.zero, zero_length);
          errors++;
        end
      end
    end
  end

  initial begin
    int kind;
    quat_t q;
    // directed: zero length, extremes, most negative, single axes, ties region
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(32767, 32767, 32767, 32767));
    pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
    pending_quats.push_back(mk(-32768, 0, 0, 0));
    pending_quats.push_back(mk(0, -32768, 0, 0));
    pending_quats.push_back(mk(0, 0, 32767, 0));
    pending_quats.push_back(mk(0, 0, 0, 32767));
    pending_quats.push_back(mk(1, 0, 0, 0));
    pending_quats.push_back(mk(0, 0, 0, -1));
    pending_quats.push_back(mk(1, 1, 1, 1));
    pending_quats.push_back(mk(-1, 1, -1, 1));
    pending_quats.push_back(mk(3, 4, 0, 0));
    pending_quats.push_back(mk(1, 2, 2, 0));
    pending_quats.push_back(mk(4096, 0, 0, 0));
    pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
    pending_quats.push_back(mk(32767, 1, 0, 0));
    pending_quats.push_back(mk(-32768, -1, 1, 0));
    pending_quats.push_back(mk(0, 0, 0, 0));
    pending_quats.push_back(mk(1, 3, 5, 7));
    pending_quats.push_back(mk(-21845, 21845, -21845, 21845));
    for (int n = 0; n < 1700; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) kind = 0; else if (kind < 8) kind = 1;
      else if (kind < 9) kind = 2; else kind = 3;
      q.x = rand_comp(kind); q.y = rand_comp(kind);
      q.z = rand_comp(kind); q.w = rand_comp(kind);
      if ($urandom_range(0, 19) == 0) begin
        // mostly one axis: y, z and w are each zeroed at random
        if ($urandom_range(0, 1)) q.y = '0;
        if ($urandom_range(0, 1)) q.z = '0;
        if ($urandom_range(0, 1)) q.w = '0;
      end
      pending_quats.push_back(q);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_quats.size() == 0);
    @(posedge clk);
    while (in_valid || expected_norms.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_norms.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
